@@ sv/dltq_pkg.sv @@
// Shared types and codes for the delta-list timer queue.
package dltq_pkg;

	localparam int FuncBits = 2;
	localparam int SlotBits = 4;
	localparam int FieldTimeBits = 24;

	localparam logic [FuncBits-1:0] FUNC_ADD = 2'd0;
	localparam logic [FuncBits-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FuncBits-1:0] FUNC_TICK = 2'd2;

	typedef logic [3:0] dltq_op_t;

	localparam dltq_op_t OP_NONE = 4'd0;
	localparam dltq_op_t OP_LOAD = 4'd1;
	localparam dltq_op_t OP_FIND = 4'd2;
	localparam dltq_op_t OP_CARRY = 4'd3;
	localparam dltq_op_t OP_SET = 4'd4;
	localparam dltq_op_t OP_INS = 4'd5;
	localparam dltq_op_t OP_PLACE = 4'd6;
	localparam dltq_op_t OP_TICK = 4'd7;
	localparam dltq_op_t OP_RELOAD = 4'd8;
	localparam dltq_op_t OP_EMIT = 4'd9;

	typedef struct packed {
		dltq_op_t op;
	} dltq_cmd_t;

	typedef struct packed {
		logic [FuncBits-1:0] func;
		logic slot_ok;
		logic req_active;
		logic match;
		logic i_end;
		logic ins_done;
		logic tick_done;
		logic k_end;
		logic rl_go;
		logic k_last;
		logic out_free;
		logic full;
	} dltq_stat_t;

endpackage

@@ sv/dltq_ctrl.sv @@
// Sequencer for the timer queue: steps the datapath through each request.
module dltq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dltq_pkg::dltq_stat_t stat,
	output dltq_pkg::dltq_cmd_t  cmd
);
	import dltq_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DECIDE = 4'd1;
	localparam logic [3:0] ST_FIND = 4'd2;
	localparam logic [3:0] ST_CARRY = 4'd3;
	localparam logic [3:0] ST_SET = 4'd4;
	localparam logic [3:0] ST_INS = 4'd5;
	localparam logic [3:0] ST_PLACE = 4'd6;
	localparam logic [3:0] ST_TICK = 4'd7;
	localparam logic [3:0] ST_RELOAD = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.func == FUNC_ADD && stat.slot_ok)
					state_d = stat.req_active ? ST_FIND : ST_SET;
				else if (stat.func == FUNC_REMOVE && stat.slot_ok && stat.req_active)
					state_d = ST_FIND;
				else if (stat.func == FUNC_TICK)
					state_d = ST_TICK;
				else
					state_d = ST_EMIT;
			end
			ST_FIND: begin
				cmd.op = OP_FIND;
				if (stat.match)
					state_d = ST_CARRY;
				else if (stat.i_end)
					state_d = ST_EMIT;
			end
			ST_CARRY: begin
				cmd.op = OP_CARRY;
				state_d = (stat.func == FUNC_ADD) ? ST_SET : ST_EMIT;
			end
			ST_SET: begin
				cmd.op = OP_SET;
				state_d = stat.full ? ST_EMIT : ST_INS;
			end
			ST_INS: begin
				cmd.op = OP_INS;
				if (stat.ins_done)
					state_d = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.op = OP_PLACE;
				state_d = (stat.func == FUNC_TICK) ? ST_RELOAD : ST_EMIT;
			end
			ST_TICK: begin
				cmd.op = OP_TICK;
				if (stat.tick_done)
					state_d = ST_RELOAD;
			end
			ST_RELOAD: begin
				cmd.op = OP_RELOAD;
				if (stat.k_end)
					state_d = ST_EMIT;
				else if (stat.rl_go)
					state_d = ST_INS;
			end
			ST_EMIT: begin
				cmd.op = OP_EMIT;
				if (stat.out_free && stat.k_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end
endmodule

@@ sv/dltq_dp.sv @@
// Datapath of the timer queue: ordered slot list, deltas, slot records and result register.
module dltq_dp #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dltq_pkg::dltq_cmd_t  cmd,
	output dltq_pkg::dltq_stat_t stat,
	input  logic [1:0]           in_func,
	input  logic [3:0]           in_slot,
	input  logic [23:0]          in_duration,
	input  logic                 in_reload,
	input  logic [23:0]          in_elapsed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_kind,
	output logic [3:0]           out_slot,
	output logic [23:0]          out_timeout,
	output logic                 out_last
);
	import dltq_pkg::*;

	localparam int SW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int CAP = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
	localparam int KW = $clog2(CAP + 1);
	localparam int KIW = $clog2(CAP);

	logic [FuncBits-1:0]  req_func_q;
	logic [SlotBits-1:0]  req_slot_q;
	logic [TIME_BITS-1:0] req_dur_q;
	logic                 req_rel_q;
	logic [TIME_BITS-1:0] e_q;

	logic [SW-1:0]        slot_at_q [NUM_TIMERS];
	logic [TIME_BITS-1:0] delta_q [NUM_TIMERS];
	logic [TIME_BITS-1:0] period_q [NUM_TIMERS];
	logic                 reload_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] active_q;
	logic [SW-1:0]        w_q [CAP];

	logic [CW-1:0]        n_q, i_q;
	logic [KW-1:0]        nexp_q, k_q;
	logic [TIME_BITS-1:0] carry_q, t_q;
	logic [SW-1:0]        s_q;

	logic [SW-1:0]        iw, rs, sl, wk;
	logic [TIME_BITS-1:0] c, head;
	logic                 i_lt_n, gt, eq, match, tick_done, full, k_end, k_last;
	logic                 slot_ok, rl_auto, rl_go, can_rec, out_free;

	assign iw = i_q[SW-1:0];
	assign rs = SW'(req_slot_q);
	assign c = delta_q[iw];
	assign sl = slot_at_q[iw];
	assign wk = w_q[k_q[KIW-1:0]];
	assign i_lt_n = (i_q < n_q);
	assign gt = (t_q > c);
	assign eq = (t_q == c);
	assign match = i_lt_n && (sl == rs);
	assign tick_done = !i_lt_n || (c > e_q);
	assign full = (n_q == CW'(NUM_TIMERS));
	assign k_end = (k_q >= nexp_q);
	assign k_last = (nexp_q == '0) || (k_q + KW'(1) == nexp_q);
	assign slot_ok = (32'(req_slot_q) < NUM_TIMERS);
	assign rl_auto = reload_q[wk];
	assign rl_go = rl_auto && !full;
	assign can_rec = (nexp_q < KW'(CAP));
	assign head = (n_q != '0) ? delta_q[0] : '0;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		stat.func = req_func_q;
		stat.slot_ok = slot_ok;
		stat.req_active = active_q[rs];
		stat.match = match;
		stat.i_end = !i_lt_n;
		stat.ins_done = !i_lt_n || !gt;
		stat.tick_done = tick_done;
		stat.k_end = k_end;
		stat.rl_go = rl_go;
		stat.k_last = k_last;
		stat.out_free = out_free;
		stat.full = full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			i_q <= '0;
			k_q <= '0;
			nexp_q <= '0;
			active_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_ready && cmd.op != OP_EMIT)
				out_valid <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					i_q <= '0;
					k_q <= '0;
					nexp_q <= '0;
				end
				OP_FIND: begin
					if (match)
						n_q <= n_q - CW'(1);
					else
						i_q <= i_q + CW'(1);
				end
				OP_CARRY: begin
					if (req_func_q == FUNC_REMOVE)
						active_q[rs] <= 1'b0;
				end
				OP_SET: begin
					active_q[rs] <= 1'b1;
					i_q <= '0;
				end
				OP_INS: begin
					if (i_lt_n && (gt || eq))
						i_q <= i_q + CW'(1);
				end
				OP_PLACE: begin
					n_q <= n_q + CW'(1);
					if (req_func_q == FUNC_TICK)
						k_q <= k_q + KW'(1);
				end
				OP_TICK: begin
					if (!tick_done) begin
						if (can_rec) begin
							nexp_q <= nexp_q + KW'(1);
							n_q <= n_q - CW'(1);
						end else begin
							i_q <= i_q + CW'(1);
						end
					end
				end
				OP_RELOAD: begin
					if (k_end) begin
						k_q <= '0;
					end else if (rl_go) begin
						i_q <= '0;
					end else begin
						if (!rl_auto)
							active_q[wk] <= 1'b0;
						k_q <= k_q + KW'(1);
					end
				end
				OP_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						k_q <= k_q + KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_func_q <= in_func;
				req_slot_q <= in_slot;
				req_dur_q <= TIME_BITS'(in_duration);
				req_rel_q <= in_reload;
				e_q <= TIME_BITS'(in_elapsed);
			end
			OP_FIND: begin
				if (match) begin
					carry_q <= c;
					for (int j = 0; j < NUM_TIMERS - 1; j++) begin
						if (SW'(j) >= iw) begin
							slot_at_q[j] <= slot_at_q[j+1];
							delta_q[j] <= delta_q[j+1];
						end
					end
				end
			end
			OP_CARRY: begin
				if (i_lt_n)
					delta_q[iw] <= c + carry_q;
			end
			OP_SET: begin
				period_q[rs] <= req_dur_q;
				reload_q[rs] <= req_rel_q;
				t_q <= req_dur_q;
				s_q <= rs;
			end
			OP_INS: begin
				if (i_lt_n) begin
					if (gt)
						t_q <= t_q - c;
					else if (eq)
						t_q <= '0;
					else
						delta_q[iw] <= c - t_q;
				end
			end
			OP_PLACE: begin
				for (int j = 1; j < NUM_TIMERS; j++) begin
					if (CW'(j) > i_q) begin
						slot_at_q[j] <= slot_at_q[j-1];
						delta_q[j] <= delta_q[j-1];
					end
				end
				slot_at_q[iw] <= s_q;
				delta_q[iw] <= t_q;
			end
			OP_TICK: begin
				if (i_lt_n) begin
					if (c > e_q) begin
						delta_q[iw] <= c - e_q;
					end else begin
						e_q <= e_q - c;
						if (can_rec) begin
							w_q[nexp_q[KIW-1:0]] <= sl;
							for (int j = 0; j < NUM_TIMERS - 1; j++) begin
								if (SW'(j) >= iw) begin
									slot_at_q[j] <= slot_at_q[j+1];
									delta_q[j] <= delta_q[j+1];
								end
							end
						end else begin
							delta_q[iw] <= '0;
						end
					end
				end
			end
			OP_RELOAD: begin
				if (!k_end && rl_go) begin
					s_q <= wk;
					t_q <= period_q[wk];
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					out_kind <= (nexp_q != '0);
					out_slot <= (nexp_q != '0) ? 4'(wk) : 4'd0;
					out_timeout <= 24'(head);
					out_last <= k_last;
				end
			end
			default: ;
		endcase
	end
endmodule

@@ sv/delta_list_timer_queue_unit.sv @@
// Top level of the delta-list timer queue: stream ports, sequencer and datapath.
// Up to NUM_TIMERS slots are held in one list sorted by expiry, each storing its delay
// relative to the slot before it. A request is add (restarts an active slot), remove, or
// tick; every request returns one acknowledge, or one result per expired slot in list
// order, each carrying the head delay left after the request. Requests are handled one at
// a time by a single list walker that visits one entry per cycle: a remove walks the list
// once, an add walks it once to unlink an active slot and again to insert, and a tick
// passes each expired entry and makes a full insertion walk for every reloading slot that
// expires. Results leave through an output register so the next request is not held by a
// stalled result.
module delta_list_timer_queue_unit #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[1:0], timer_slot[5:2], duration[29:6], reload_enable[30], elapsed[54:31]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// expired_slot[3:0], first_timeout[27:4]
	output logic [31:0] m_tdata,
	// result_kind[0]
	output logic [0:0]  m_tuser,
	output logic        m_tlast
);
	import dltq_pkg::*;

	dltq_cmd_t   cmd;
	dltq_stat_t  stat;
	logic        out_kind;
	logic [3:0]  out_slot;
	logic [23:0] out_timeout;

	dltq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dltq_dp #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_func     (s_tdata[1:0]),
		.in_slot     (s_tdata[5:2]),
		.in_duration (s_tdata[29:6]),
		.in_reload   (s_tdata[30]),
		.in_elapsed  (s_tdata[54:31]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (out_kind),
		.out_slot    (out_slot),
		.out_timeout (out_timeout),
		.out_last    (m_tlast)
	);

	assign m_tdata = {4'd0, out_timeout, out_slot};
	assign m_tuser = out_kind;
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the delta-list timer queue unit.
module tb;
	import dltq_pkg::*;

	localparam int NT = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] slot;
		logic [23:0] duration;
		logic reload;
		logic [23:0] elapsed;
	} request_t;

	typedef struct packed {
		logic kind;
		logic [3:0] slot;
		logic [23:0] head;
		logic last;
	} timer_event_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;

	delta_list_timer_queue_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	request_t pending_requests[$];
	timer_event_t expected_events[$];
	request_t cur_req;
	logic [23:0] delta_of[NT];
	logic [23:0] period_of[NT];
	logic reload_of[NT];
	logic active_of[NT];
	int order[$];
	int errors;
	int idle_count;
	int send_gap;
	int recv_gap;
	int hold_cycles;
	bit in_fire;
	bit stim_done;

	function automatic bit no_idle();
		return pending_requests.size() < 30;
	endfunction

	function automatic logic [55:0] pack_request(request_t r);
		return {1'b0, r.elapsed, r.reload, r.duration, r.slot, r.func};
	endfunction

	task automatic unlink_timer(int s);
		for (int i = 0; i < order.size(); i++) begin
			if (order[i] == s) begin
				if (i + 1 < order.size())
					delta_of[order[i+1]] = delta_of[order[i+1]] + delta_of[s];
				order.delete(i);
				return;
			end
		end
	endtask

	task automatic place_timer(int s, logic [23:0] t);
		int pos;
		pos = order.size();
		for (int i = 0; i < order.size(); i++) begin
			if (t > delta_of[order[i]]) begin
				t = t - delta_of[order[i]];
			end else if (t == delta_of[order[i]]) begin
				t = 0;
				pos = i + 1;
				break;
			end else begin
				delta_of[order[i]] = delta_of[order[i]] - t;
				pos = i;
				break;
			end
		end
		order.insert(pos, s);
		delta_of[s] = t;
	endtask

	task automatic predict_request(request_t r);
		int fired[$];
		logic [23:0] e;
		logic [23:0] head;
		int s;
		e = r.elapsed;
		if (r.func == FUNC_ADD) begin
			if (active_of[r.slot])
				unlink_timer(r.slot);
			period_of[r.slot] = r.duration;
			reload_of[r.slot] = r.reload;
			active_of[r.slot] = 1'b1;
			place_timer(r.slot, r.duration);
		end else if (r.func == FUNC_REMOVE) begin
			if (active_of[r.slot]) begin
				unlink_timer(r.slot);
				active_of[r.slot] = 1'b0;
			end
		end else if (r.func == FUNC_TICK) begin
			while (order.size() > 0) begin
				s = order[0];
				if (delta_of[s] > e) begin
					delta_of[s] = delta_of[s] - e;
					break;
				end
				e = e - delta_of[s];
				delta_of[s] = 0;
				fired.push_back(s);
				void'(order.pop_front());
			end
			foreach (fired[k]) begin
				if (reload_of[fired[k]])
					place_timer(fired[k], period_of[fired[k]]);
				else
					active_of[fired[k]] = 1'b0;
			end
		end
		head = order.size() ? delta_of[order[0]] : 24'd0;
		if (fired.size() == 0)
			expected_events.push_back('{1'b0, 4'd0, head, 1'b1});
		foreach (fired[k])
			expected_events.push_back('{1'b1, fired[k][3:0], head, k == fired.size() - 1});
	endtask

	function automatic request_t make_request(logic [1:0] f, int s, logic [23:0] d, bit rl,
			logic [23:0] el);
		request_t r;
		r.func = f;
		r.slot = s[3:0];
		r.duration = d;
		r.reload = rl;
		r.elapsed = el;
		return r;
	endfunction

	function automatic logic [23:0] rand_time();
		case ($urandom_range(0, 3))
			0: return 24'($urandom_range(0, 3));
			1: return 24'($urandom_range(0, 40));
			2: return 24'($urandom_range(0, 1000));
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Directed requests, then random ones.
	initial begin
		logic [1:0] f;
		int n;
		for (int i = 0; i < NT; i++)
			active_of[i] = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'd5));
		pending_requests.push_back(make_request(FUNC_REMOVE, 3, 0, 0, 0));
		pending_requests.push_back(make_request(2'd3, 15, 24'hFFFFFF, 1, 24'hFFFFFF));
		pending_requests.push_back(make_request(FUNC_ADD, 0, 24'd10, 0, 0));
		pending_requests.push_back(make_request(FUNC_ADD, 1, 24'd10, 1, 0));
		pending_requests.push_back(make_request(FUNC_ADD, 2, 24'd4, 1, 0));
		pending_requests.push_back(make_request(FUNC_ADD, 15, 24'hFFFFFF, 0, 0));
		pending_requests.push_back(make_request(FUNC_ADD, 3, 24'd0, 0, 0));
		pending_requests.push_back(make_request(FUNC_ADD, 0, 24'd12, 0, 0));
		pending_requests.push_back(make_request(FUNC_REMOVE, 2, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'd0));
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'd10));
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'd2));
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'hFFFFFF));
		for (int i = 0; i < NT; i++)
			pending_requests.push_back(make_request(FUNC_ADD, i, 24'd7, i[0], 0));
		pending_requests.push_back(make_request(FUNC_TICK, 0, 0, 0, 24'd7));
		for (int i = 0; i < 150; i++) begin
			n = $urandom_range(0, 9);
			f = n < 5 ? FUNC_ADD : n < 7 ? FUNC_REMOVE : n < 9 ? FUNC_TICK : 2'd3;
			pending_requests.push_back(make_request(f, $urandom_range(0, 15), rand_time(),
				1'($urandom_range(0, 1)), rand_time()));
		end
		wait (pending_requests.size() == 0 && !s_tvalid);
		stim_done = 1'b1;
	end

	// Request driver.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else if (s_tvalid && !in_fire) begin
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_requests.size() > 0) begin
			cur_req = pending_requests.pop_front();
			predict_request(cur_req);
			s_tvalid <= 1'b1;
			s_tdata <= pack_request(cur_req);
			if (!no_idle() && $urandom_range(0, 5) == 0)
				send_gap <= $urandom_range(1, 9);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Result sink; one long hold-off early in the run fills the block.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_cycles <= 0;
		end else if (hold_cycles < 300 && pending_requests.size() < 170
				&& pending_requests.size() > 120) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else if (recv_gap > 0) begin
			m_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else if (!no_idle() && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			recv_gap <= $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		timer_event_t want;
		in_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$display("%0t unexpected result: actual %h/%h/%b", $time, m_tuser, m_tdata,
						m_tlast);
					errors <= errors + 1;
				end else begin
					want = expected_events.pop_front();
					if (m_tuser[0] !== want.kind || m_tdata[3:0] !== want.slot
							|| m_tdata[27:4] !== want.head || m_tlast !== want.last) begin
						$display({"%0t mismatch: expected kind %b slot %0d head %0d last %b,",
							" actual kind %b slot %0d head %0d last %b"},
							$time, want.kind, want.slot, want.head, want.last, m_tuser[0],
							m_tdata[3:0], m_tdata[27:4], m_tlast);
						errors <= errors + 1;
					end
				end
			end
		end else begin
			idle_count <= 0;
		end
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (stim_done && expected_events.size() == 0);
				repeat (100) @(posedge clk);
			end
			wait (idle_count >= WATCHDOG_LIMIT);
		join_any
		if (idle_count < WATCHDOG_LIMIT && errors == 0 && expected_events.size() == 0)
			$display("[delta_list_timer_queue_unit] OK");
		else
			$display("[delta_list_timer_queue_unit] ERROR");
		$finish;
	end
endmodule

@@ sim.f @@
sv/dltq_pkg.sv
sv/dltq_ctrl.sv
sv/dltq_dp.sv
sv/delta_list_timer_queue_unit.sv
dv/tb.sv
